// ===== rtl/srrc_pkg.sv =====
// shared types and constants for the symbol rate register calculator
// no dependencies; used by every module of the block by scoped names

package srrc_pkg;

	// crystal clock and derived reference
	localparam logic [31:0] XinHz = 32'd57840000;
	localparam logic [31:0] FinHz = XinHz >> 4;
	localparam logic [31:0] RateMin = 32'd500000;
	localparam logic [31:0] RateMax = XinHz >> 1;

	// decimation thresholds
	localparam logic [31:0] Dec1 = XinHz >> 4;
	localparam logic [31:0] Dec2 = XinHz >> 5;
	localparam logic [31:0] Dec3 = XinHz >> 6;

	// filter thresholds, xin over 12.3, 24.6, 49.2 and 98.4, truncated
	localparam logic [31:0] SfilT1 = 32'd4702439;
	localparam logic [31:0] SfilT2 = 32'd2351219;
	localparam logic [31:0] SfilT3 = 32'd1175609;
	localparam logic [31:0] SfilT4 = 32'd587804;

	// rounding bias for the ratio and numerator of the inverse ratio
	localparam logic [31:0] RoundBias = FinHz >> 1;
	localparam logic [31:0] InvNum = XinHz << 5;

	// widths
	localparam int RateW = 25;          // clamped and shifted rate
	localparam int FracW = 20;          // rate * 16 * 2^16
	localparam int DivW = RateW + FracW;
	localparam int QuoW = 24;           // ratio quotient bits, one per cell
	localparam int RemW = 22;           // ratio remainder, below fin
	localparam int InvQuoW = 10;        // inverse quotient bits
	localparam int InvW = RateW;        // inverse remainder and divisor
	localparam int NumCells = QuoW;

	// configuration register indexes
	localparam logic RegNdecBase = 1'b0;
	localparam logic RegSfilBase = 1'b1;

	localparam logic [7:0] NdecBaseReset = 8'd18;
	localparam logic [7:0] SfilBaseReset = 8'd67;

	// item as it travels along the divider cells
	typedef struct packed {
		logic [1:0]         ndec;
		logic               sfil;
		logic [RemW-1:0]    rem;
		logic [QuoW-1:0]    dbits;
		logic [QuoW-1:0]    quo;
		logic [InvW-1:0]    inv_rem;
		logic [InvW-1:0]    inv_div;
		logic [InvQuoW-1:0] inv_quo;
	} item_t;

endpackage

// ===== rtl/srrc_front.sv =====
// front stages: clamp, decimation and filter select, divider set-up
// depends on srrc_pkg

module srrc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [31:0]         req_rate,
	output logic                out_vld,
	output srrc_pkg::item_t     out_item
);

	logic [srrc_pkg::RateW-1:0] rate_s1;
	logic                       vld_s1;
	logic [31:0]                clamped;

	logic [1:0]                 ndec;
	logic                       sfil;
	logic [31:0]                rate_w;
	logic [srrc_pkg::RateW-1:0] shifted;
	logic [srrc_pkg::DivW-1:0]  dividend;
	srrc_pkg::item_t            item_c;

	always_comb begin
		clamped = req_rate;
		if (clamped > srrc_pkg::RateMax) begin
			clamped = srrc_pkg::RateMax;
		end
		if (clamped < srrc_pkg::RateMin) begin
			clamped = srrc_pkg::RateMin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rate_s1 <= clamped[srrc_pkg::RateW-1:0];
	end

	always_comb begin
		rate_w = {{(32-srrc_pkg::RateW){1'b0}}, rate_s1};
		ndec = 2'd0;
		if (rate_w < srrc_pkg::Dec1) ndec = 2'd1;
		if (rate_w < srrc_pkg::Dec2) ndec = 2'd2;
		if (rate_w < srrc_pkg::Dec3) ndec = 2'd3;

		// filter bit toggles across the interleaved thresholds
		sfil = 1'b0;
		if (rate_w < srrc_pkg::SfilT1) sfil = 1'b1;
		if (rate_w < srrc_pkg::Dec1)   sfil = 1'b0;
		if (rate_w < srrc_pkg::SfilT2) sfil = 1'b1;
		if (rate_w < srrc_pkg::Dec2)   sfil = 1'b0;
		if (rate_w < srrc_pkg::SfilT3) sfil = 1'b1;
		if (rate_w < srrc_pkg::Dec3)   sfil = 1'b0;
		if (rate_w < srrc_pkg::SfilT4) sfil = 1'b1;

		shifted = rate_s1 << ndec;
		dividend = {shifted, {srrc_pkg::FracW{1'b0}}}
			+ srrc_pkg::DivW'(srrc_pkg::RoundBias);

		item_c.ndec = ndec;
		item_c.sfil = sfil;
		item_c.rem = {1'b0, dividend[srrc_pkg::DivW-1:srrc_pkg::QuoW]};
		item_c.dbits = dividend[srrc_pkg::QuoW-1:0];
		item_c.quo = '0;
		item_c.inv_rem = srrc_pkg::InvW'(srrc_pkg::InvNum >> srrc_pkg::InvQuoW);
		item_c.inv_div = shifted;
		item_c.inv_quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_item <= item_c;
	end

endmodule

// ===== rtl/srrc_cell.sv =====
// one divider cell: a restoring step of the ratio and, in the first cells,
// of the inverse ratio; depends on srrc_pkg

module srrc_cell #(
	parameter int STEP = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  srrc_pkg::item_t in_item,
	output logic            out_vld,
	output srrc_pkg::item_t out_item
);

	localparam bit InvEn = (STEP < srrc_pkg::InvQuoW);
	localparam int InvPos = InvEn ? (srrc_pkg::InvQuoW - 1 - STEP) : 0;
	localparam logic [srrc_pkg::RemW:0] DivF = (srrc_pkg::RemW + 1)'(srrc_pkg::FinHz);
	localparam logic InvBit = srrc_pkg::InvNum[InvPos];

	logic [srrc_pkg::RemW:0] trial;
	logic                    ge;
	logic [srrc_pkg::RemW:0] diff;
	logic [srrc_pkg::InvW:0] inv_trial;
	logic [srrc_pkg::InvW:0] inv_diff;
	logic                    inv_ge;
	srrc_pkg::item_t         item_c;

	always_comb begin
		trial = {in_item.rem, in_item.dbits[srrc_pkg::QuoW-1]};
		ge = (trial >= DivF);
		diff = trial - DivF;

		inv_trial = {in_item.inv_rem, InvBit};
		inv_ge = (inv_trial >= {1'b0, in_item.inv_div});
		inv_diff = inv_trial - {1'b0, in_item.inv_div};

		item_c = in_item;
		item_c.rem = ge ? diff[srrc_pkg::RemW-1:0] : trial[srrc_pkg::RemW-1:0];
		item_c.dbits = {in_item.dbits[srrc_pkg::QuoW-2:0], 1'b0};
		item_c.quo = {in_item.quo[srrc_pkg::QuoW-2:0], ge};
		if (InvEn) begin
			item_c.inv_rem = inv_ge ? inv_diff[srrc_pkg::InvW-1:0]
				: inv_trial[srrc_pkg::InvW-1:0];
			item_c.inv_quo = {in_item.inv_quo[srrc_pkg::InvQuoW-2:0], inv_ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		out_item <= item_c;
	end

endmodule

// ===== rtl/srrc_out.sv =====
// result stage: inverse ratio rounding and saturation, register byte merge
// depends on srrc_pkg

module srrc_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  srrc_pkg::item_t in_item,
	input  logic [7:0]      ndec_base,
	input  logic [7:0]      sfil_base,
	output logic            done,
	output logic [7:0]      ndec_reg,
	output logic [21:0]     bdr_value,
	output logic [7:0]      bdri_value,
	output logic [7:0]      sfil_reg
);

	logic [srrc_pkg::InvQuoW:0]   inv_inc;
	logic [srrc_pkg::InvQuoW-1:0] inv_half;
	logic [7:0]                   bdri_c;

	always_comb begin
		inv_inc = {1'b0, in_item.inv_quo} + {{srrc_pkg::InvQuoW{1'b0}}, 1'b1};
		inv_half = inv_inc[srrc_pkg::InvQuoW:1];
		bdri_c = (inv_half > 10'd255) ? 8'hFF : inv_half[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		ndec_reg <= {in_item.ndec, 6'd0} | ndec_base;
		bdr_value <= in_item.quo[21:0];
		bdri_value <= bdri_c;
		sfil_reg <= {3'd0, in_item.sfil, 4'd0} | sfil_base;
	end

endmodule

// ===== rtl/symbol_rate_register_calc.sv =====
// top level of the symbol rate register calculator
// depends on srrc_pkg, srrc_front, srrc_cell and srrc_out
// an accepted start reaches the done strobe through two front stages,
// 24 divider cells and one result stage
// throughput: one item per cycle; busy is never raised, the receiver cannot stall
// reset: clears every valid flag and sets ndec_base to 18, sfil_base to 67

module symbol_rate_register_calc (
	input  logic        clk,
	input  logic        arst_n,
	// item request
	input  logic        start,
	output logic        busy,
	input  logic [31:0] req_rate,
	// configuration write port
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	// result
	output logic        done,
	output logic [7:0]  ndec_reg,
	output logic [21:0] bdr_value,
	output logic [7:0]  bdri_value,
	output logic [7:0]  sfil_reg
);

	localparam int Latency = srrc_pkg::NumCells + 3;

	logic [7:0]      ndec_base_q;
	logic [7:0]      sfil_base_q;
	logic            accept;

	// valid flags and items between neighbouring cells
	logic            chain_vld [0:srrc_pkg::NumCells];
	srrc_pkg::item_t chain_item [0:srrc_pkg::NumCells];

	// every stage moves on every cycle, so a request is always taken
	assign busy = 1'b0;
	assign accept = start && !busy;

	// configuration registers, unchecked: write only while no item is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ndec_base_q <= srrc_pkg::NdecBaseReset;
			sfil_base_q <= srrc_pkg::SfilBaseReset;
		end else if (wr_en) begin
			unique case (wr_index)
				srrc_pkg::RegNdecBase: ndec_base_q <= wr_data;
				srrc_pkg::RegSfilBase: sfil_base_q <= wr_data;
				default: ;
			endcase
		end
	end

	// clamp the rate, pick decimation and filter, build the dividends
	srrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (accept),
		.req_rate    (req_rate),
		.out_vld     (chain_vld[0]),
		.out_item    (chain_item[0])
	);

	// row of restoring division cells: each yields one bit of the rounded
	// ratio against fin, the first ten also one bit of xin*32 over the shifted rate
	for (genvar g = 0; g < srrc_pkg::NumCells; g++) begin : g_cell
		srrc_cell #(
			.STEP (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (chain_vld[g]),
			.in_item  (chain_item[g]),
			.out_vld  (chain_vld[g+1]),
			.out_item (chain_item[g+1])
		);
	end

	// round and saturate the inverse ratio, merge in the base bytes
	srrc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (chain_vld[srrc_pkg::NumCells]),
		.in_item    (chain_item[srrc_pkg::NumCells]),
		.ndec_base  (ndec_base_q),
		.sfil_base  (sfil_base_q),
		.done       (done),
		.ndec_reg   (ndec_reg),
		.bdr_value  (bdr_value),
		.bdri_value (bdri_value),
		.sfil_reg   (sfil_reg)
	);

	// every accepted item comes out after the fixed latency
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##Latency done)
		else $error("accepted item did not complete on time");

	// no result without a request the fixed latency earlier
	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, Latency))
		else $error("result strobe without a matching request");

	// the clamped rate keeps the inverse ratio at 32 or more
	a_bdri_floor : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bdri_value >= 8'd32))
		else $error("inverse ratio below its lower bound");

endmodule

// ===== verif/tb_symbol_rate_register_calc.sv =====
`timescale 1ns / 100ps

// self-checking bench for symbol_rate_register_calc: rate requests and base
// register writes, each result checked against an in-bench model of the register maths
// depends on srrc_pkg and the rtl of the block, nothing else

module tb_symbol_rate_register_calc;

	// crystal, reference and clamp limits, kept wide so the divisions stay exact
	localparam logic [63:0] Xin = 64'd57840000;
	localparam logic [63:0] Fin = Xin >> 4;
	localparam logic [63:0] RateLo = 64'd500000;
	localparam logic [63:0] RateHi = Xin >> 1;
	// filter thresholds, xin over 12.3, 24.6, 49.2 and 98.4 truncated
	localparam logic [63:0] Fil1 = 64'd4702439;
	localparam logic [63:0] Fil2 = 64'd2351219;
	localparam logic [63:0] Fil3 = 64'd1175609;
	localparam logic [63:0] Fil4 = 64'd587804;
	localparam logic [63:0] InvMax = 64'd255;

	localparam int SettleCycles = 40;      // extra wait after the last result, as margin
	localparam int CycleLimit = 400000;
	localparam int ReportLimit = 10;
	localparam int NumPhases = 6;
	localparam int ItemsPerPhase = 300;

	typedef enum logic [1:0] {
		OpRate,
		OpWrite,
		OpDrain
	} op_kind_t;

	// one entry of the stimulus list: a rate item, a base register write or a drain
	typedef struct packed {
		op_kind_t    kind;
		logic [31:0] rate;
		logic        idx;
		logic [7:0]  data;
		logic [7:0]  gap;
	} stim_op_t;

	typedef struct packed {
		logic [7:0]  ndec;
		logic [21:0] bdr;
		logic [7:0]  bdri;
		logic [7:0]  sfil;
	} reg_values_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] req_rate;
	logic        wr_en;
	logic        wr_index;
	logic [7:0]  wr_data;
	logic        done;
	logic [7:0]  ndec_reg;
	logic [21:0] bdr_value;
	logic [7:0]  bdri_value;
	logic [7:0]  sfil_reg;

	stim_op_t    pending_ops[$];
	reg_values_t results_due[$];

	// mirror of the two base registers, updated as the writes land
	logic [7:0]  ndec_base_copy;
	logic [7:0]  sfil_base_copy;

	logic        drive_on;
	logic        item_taken;
	int unsigned gap_left;
	int unsigned mismatches;
	int unsigned cycle_count;

	symbol_rate_register_calc dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_rate   (req_rate),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.done       (done),
		.ndec_reg   (ndec_reg),
		.bdr_value  (bdr_value),
		.bdri_value (bdri_value),
		.sfil_reg   (sfil_reg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register values for one requested rate under the given base bytes
	function automatic reg_values_t calc_reg_values(input logic [31:0] req,
			input logic [7:0] nbase, input logic [7:0] sbase);
		logic [63:0] sr;
		logic [63:0] num;
		logic [63:0] quo;
		logic [63:0] rem;
		logic [63:0] inv;
		logic [1:0]  dec;
		logic        fil;
		reg_values_t v;
		sr = {32'd0, req};
		if (sr > RateHi)
			sr = RateHi;
		if (sr < RateLo)
			sr = RateLo;
		// decimation count steps up each time the rate halves below xin/16
		dec = 2'd0;
		if (sr < (Xin >> 4))
			dec = 2'd1;
		if (sr < (Xin >> 5))
			dec = 2'd2;
		if (sr < (Xin >> 6))
			dec = 2'd3;
		// filter bit is set in the lower band of each octave, cleared above it
		fil = 1'b0;
		if (sr < Fil1)
			fil = 1'b1;
		if (sr < (Xin >> 4))
			fil = 1'b0;
		if (sr < Fil2)
			fil = 1'b1;
		if (sr < (Xin >> 5))
			fil = 1'b0;
		if (sr < Fil3)
			fil = 1'b1;
		if (sr < (Xin >> 6))
			fil = 1'b0;
		if (sr < Fil4)
			fil = 1'b1;
		sr = sr << dec;
		// ratio rate*16/fin as integer part plus two fraction bytes, last one rounded
		num = sr << 4;
		quo = num / Fin;
		rem = (num % Fin) << 8;
		quo = (quo << 8) + rem / Fin;
		rem = (rem % Fin) << 8;
		quo = (quo << 8) + (rem + (Fin >> 1)) / Fin;
		// inverse ratio, rounded half up, saturated to one byte
		inv = ((Xin << 5) / sr + 64'd1) >> 1;
		if (inv > InvMax)
			inv = InvMax;
		v.ndec = {dec, 6'd0} | nbase;
		v.bdr  = quo[21:0];
		v.bdri = inv[7:0];
		v.sfil = {3'd0, fil, 4'd0} | sbase;
		return v;
	endfunction

	task automatic add_rate(input logic [31:0] r, input int unsigned g);
		stim_op_t op;
		op = '0;
		op.kind = OpRate;
		op.rate = r;
		op.gap = g[7:0];
		pending_ops.push_back(op);
	endtask

	task automatic add_write(input logic idx, input logic [7:0] d);
		stim_op_t op;
		op = '0;
		op.kind = OpWrite;
		op.idx = idx;
		op.data = d;
		pending_ops.push_back(op);
	endtask

	task automatic add_drain(input int unsigned g);
		stim_op_t op;
		op = '0;
		op.kind = OpDrain;
		op.gap = g[7:0];
		pending_ops.push_back(op);
	endtask

	// gap after an item: mostly none, often a short one, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 60);
	endfunction

	// driver: changes inputs on the falling edge, one item or write per cycle at most
	always @(negedge clk) begin : driver
		logic     next_start;
		logic     next_wr;
		stim_op_t op;
		// a start still waiting on busy is held as it stands
		if (drive_on && !(start && !item_taken)) begin
			next_start = 1'b0;
			next_wr = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
			end else if (pending_ops.size() != 0) begin
				op = pending_ops[0];
				case (op.kind)
					OpRate: begin
						next_start = 1'b1;
						req_rate <= op.rate;
						gap_left = {24'd0, op.gap};
						pending_ops.delete(0);
					end
					// every item gives a result, so an empty queue means nothing in flight
					OpWrite: begin
						if (results_due.size() == 0) begin
							next_wr = 1'b1;
							wr_index <= op.idx;
							wr_data <= op.data;
							pending_ops.delete(0);
						end
					end
					OpDrain: begin
						if (results_due.size() == 0) begin
							gap_left = {24'd0, op.gap};
							pending_ops.delete(0);
						end
					end
					default: pending_ops.delete(0);
				endcase
			end
			start <= next_start;
			wr_en <= next_wr;
		end
	end

	// monitor: samples on the rising edge, checks results, then books new items
	always @(posedge clk) begin : monitor
		reg_values_t want;
		if (arst_n) begin
			cycle_count++;
			// result first: nothing accepted on this edge can already be out
			if (done) begin
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= ReportLimit)
						$display("unexpected result: ndec %h bdr %h bdri %h sfil %h",
							ndec_reg, bdr_value, bdri_value, sfil_reg);
				end else begin
					want = results_due.pop_front();
					if (ndec_reg !== want.ndec || bdr_value !== want.bdr
							|| bdri_value !== want.bdri || sfil_reg !== want.sfil) begin
						mismatches++;
						if (mismatches <= ReportLimit) begin
							$write("mismatch at cycle %0d: ndec %h/%h bdr %h/%h ",
								cycle_count, want.ndec, ndec_reg, want.bdr, bdr_value);
							$display("bdri %h/%h sfil %h/%h (expected/actual)",
								want.bdri, bdri_value, want.sfil, sfil_reg);
						end
					end
				end
			end
			item_taken = start && !busy;
			if (wr_en) begin
				if (wr_index == srrc_pkg::RegNdecBase)
					ndec_base_copy = wr_data;
				else
					sfil_base_copy = wr_data;
			end
			if (item_taken)
				results_due.push_back(calc_reg_values(req_rate, ndec_base_copy,
					sfil_base_copy));
			if (cycle_count > CycleLimit) begin
				$display("symbol_rate_register_calc regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] corner_rates [24];
		logic [31:0] thresholds [9];
		logic [7:0]  nb;
		logic [7:0]  sb;
		logic [31:0] rate;
		int unsigned sel;
		int unsigned g;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req_rate = '0;
		wr_en = 1'b0;
		wr_index = srrc_pkg::RegNdecBase;
		wr_data = '0;
		drive_on = 1'b0;
		item_taken = 1'b0;
		gap_left = 0;
		mismatches = 0;
		cycle_count = 0;
		ndec_base_copy = srrc_pkg::NdecBaseReset;
		sfil_base_copy = srrc_pkg::SfilBaseReset;

		// clamp edges and both sides of every decimation and filter threshold
		corner_rates = '{32'd0, 32'd1, 32'd499999, 32'd500000, 32'd500001,
			32'd587803, 32'd587804, 32'd903749, 32'd903750, 32'd1175608,
			32'd1175609, 32'd1807499, 32'd1807500, 32'd2351218, 32'd2351219,
			32'd3614999, 32'd3615000, 32'd4702438, 32'd4702439, 32'd28919999,
			32'd28920000, 32'd28920001, 32'h8000_0000, 32'hFFFF_FFFF};
		thresholds = '{32'd500000, 32'd587804, 32'd903750, 32'd1175609, 32'd1807500,
			32'd2351219, 32'd3615000, 32'd4702439, 32'd28920000};

		// directed part runs on the reset bases, with a full drain half way
		for (int i = 0; i < 24; i++) begin
			add_rate(corner_rates[i], i % 3);
			if (i == 11)
				add_drain(5);
		end

		// random phases, each under its own pair of bases; first two are the extremes
		for (int phase = 0; phase < NumPhases; phase++) begin
			case (phase)
				0: begin
					nb = 8'h00;
					sb = 8'h00;
				end
				1: begin
					nb = 8'hFF;
					sb = 8'hFF;
				end
				default: begin
					nb = 8'($urandom_range(0, 255));
					sb = 8'($urandom_range(0, 255));
				end
			endcase
			add_write(srrc_pkg::RegNdecBase, nb);
			add_write(srrc_pkg::RegSfilBase, sb);
			for (int n = 0; n < ItemsPerPhase; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 50)
					rate = $urandom_range(500000, 28920000);
				else if (sel < 70)
					// close to a threshold, either side
					rate = thresholds[$urandom_range(0, 8)] + $urandom_range(0, 6) - 3;
				else if (sel < 85)
					rate = $urandom;
				else
					rate = $urandom_range(0, 499999);
				// odd phases open with a back-to-back burst
				if (phase % 2 == 1 && n < 100)
					g = 0;
				else
					g = pick_gap();
				add_rate(rate, g);
				if ($urandom_range(0, 99) == 0)
					add_drain($urandom_range(0, 3));
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);
		drive_on = 1'b1;

		// sample well clear of both edges so driver and monitor have settled
		do begin
			@(negedge clk);
			#1;
		end while (pending_ops.size() != 0 || start || results_due.size() != 0);
		repeat (SettleCycles) @(negedge clk);
		#1;
		if (mismatches == 0 && results_due.size() == 0)
			$display("symbol_rate_register_calc regression: pass");
		else
			$display("symbol_rate_register_calc regression: fail");
		$finish;
	end

endmodule
